// ===== src/ecsm_pkg.sv =====
// Shared types and codes of the elliptic-curve point arithmetic core.
`timescale 1ns / 1ps
`default_nettype none
package ecsm_pkg;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SCALE = 1'b1;

  localparam logic CFG_CURVE_A = 1'b0;
  localparam logic CFG_MODULUS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_SETUP,
    ST_LOOP,
    ST_PT,
    ST_DEN,
    ST_INV_CHK,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_NUM1,
    ST_NUM2,
    ST_SLOPE,
    ST_SQ,
    ST_YMUL,
    ST_COMMIT,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== src/ecsm_mulmod.sv =====
// Bit-serial modular multiplier, one bit of the second operand per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ecsm_mulmod import ecsm_pkg::*; #(
  parameter int W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] op_a_i,
  input  wire logic [W-1:0] op_b_i,
  input  wire logic [W-1:0] mod_i,
  output logic              done_o,
  output logic [W-1:0]      prod_o
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  a_q, b_q, m_q, r_q, r_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  always_comb begin
    r_d = mod_add(r_q, r_q, m_q);
    if (b_q[W-1]) begin
      r_d = mod_add(r_d, a_q, m_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= op_a_i;
      b_q <= op_b_i;
      m_q <= mod_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule
`default_nettype wire

// ===== src/ecsm_divu.sv =====
// Bit-serial restoring divider giving quotient and remainder, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ecsm_divu import ecsm_pkg::*; #(
  parameter int W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  d_q, rem_q, quo_q;
  logic [W:0]    trial, diff;
  logic          ge;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== src/ec_affine_scalar_multiplier_core.sv =====
// Top level of the affine elliptic-curve point addition and scalar multiplication core.
//
// Usage: write curve_a (index 0) and field_modulus (index 1) through the
// write port while the core is idle; a modulus below three acts as three.
// An item is taken at a clock edge where start is high and busy is low. It
// asks for A+B (operation 0) or scalar*A (operation 1). One result item
// follows on result_x_o, result_y_o and result_at_infinity_o, shown for one
// cycle with done_o high; busy falls in the cycle after it. The receiver
// cannot stall, so it must capture the result in that cycle.
// All inputs and curve_a are first reduced by a bit-serial divider. Each
// point operation costs one modular inversion by extended Euclid, with one
// division and one multiply per quotient step and up to about 1.44*W steps
// (W = COORD_BITS), plus up to five serial multiplies.
// A scalar multiplication runs one doubling per scalar bit above bit zero,
// up to the highest set bit, and one addition per set bit above bit zero,
// so up to 2*(SCALAR_BITS-1) point operations.
// Reset returns curve_a to 2, field_modulus to 17 and the core to idle.
`timescale 1ns / 1ps
`default_nettype none
module ec_affine_scalar_multiplier_core import ecsm_pkg::*; #(
  parameter int COORD_BITS  = 64,
  parameter int SCALAR_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [63:0] point_a_x_i,
  input  wire logic [63:0] point_a_y_i,
  input  wire logic [63:0] point_b_x_i,
  input  wire logic [63:0] point_b_y_i,
  input  wire logic [63:0] scalar_i,
  output logic             done_o,
  output logic [63:0]      result_x_o,
  output logic [63:0]      result_y_o,
  output logic             result_at_infinity_o
);

  localparam int W = COORD_BITS;
  localparam int S = SCALAR_BITS;

  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    return (x - y) + ((x < y) ? m : '0);
  endfunction

  state_e state_q, state_d;
  logic   launch_q, launch_d, relaunch;

  logic [W-1:0] cfg_a_q, cfg_m_q;
  logic [W-1:0] md_q, ar_q;
  logic [W-1:0] ax_q, ay_q, bx_q, by_q;
  logic [S-1:0] k_q;
  logic         op_q, dbl_q, in_add_q;
  logic [2:0]   red_q;
  logic [W-1:0] ux_q, uy_q, vx_q, vy_q, tx_q, ty_q;
  logic [W-1:0] t1_q, s_q, w_q;
  logic [W-1:0] r0_q, r1_q, i0_q, i1_q;

  logic         mul_start, mul_done, div_start, div_done;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic [W-1:0] div_n, div_d, div_q, div_r;

  logic [W-1:0] px, py, negvy, den, qmod, c3, red_sel;
  logic         u_zero, v_zero;

  assign px     = dbl_q ? vx_q : ux_q;
  assign py     = dbl_q ? vy_q : uy_q;
  assign negvy  = (vy_q != '0) ? (md_q - vy_q) : '0;
  assign den    = dbl_q ? mod_add(vy_q, vy_q, md_q) : mod_sub(ux_q, vx_q, md_q);
  assign qmod   = (div_q == md_q) ? '0 : div_q;
  assign c3     = (md_q == W'(3)) ? '0 : W'(3);
  assign u_zero = (ux_q == '0) && (uy_q == '0);
  assign v_zero = (vx_q == '0) && (vy_q == '0);

  always_comb begin
    unique case (red_q)
      3'd0:    red_sel = ax_q;
      3'd1:    red_sel = ay_q;
      3'd2:    red_sel = bx_q;
      3'd3:    red_sel = by_q;
      default: red_sel = cfg_a_q;
    endcase
  end

  ecsm_mulmod #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .mod_i   (md_q),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  ecsm_divu #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // Next state.
  always_comb begin
    state_d  = state_q;
    relaunch = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_RED;
      end
      ST_RED: begin
        if (div_done) begin
          if (red_q == 3'd4) state_d = ST_SETUP;
          else relaunch = 1'b1;
        end
      end
      ST_SETUP: begin
        if (op_q == OP_ADD) state_d = ST_PT;
        else if (k_q == '0) state_d = ST_DONE;
        else state_d = ST_LOOP;
      end
      ST_LOOP: begin
        state_d = (k_q == '0) ? ST_DONE : ST_PT;
      end
      ST_PT: begin
        if (dbl_q) begin
          state_d = (vy_q == '0) ? ST_COMMIT : ST_DEN;
        end else begin
          priority if (u_zero || v_zero) state_d = ST_COMMIT;
          else if (ux_q == vx_q && uy_q == negvy) state_d = ST_COMMIT;
          else if (ux_q == vx_q && uy_q == vy_q) state_d = ST_PT;
          else state_d = ST_DEN;
        end
      end
      ST_DEN:     state_d = ST_INV_CHK;
      ST_INV_CHK: begin
        if (r1_q != '0) state_d = ST_INV_DIV;
        else state_d = dbl_q ? ST_NUM1 : ST_SLOPE;
      end
      ST_INV_DIV: if (div_done) state_d = ST_INV_MUL;
      ST_INV_MUL: if (mul_done) state_d = ST_INV_CHK;
      ST_NUM1:    if (mul_done) state_d = ST_NUM2;
      ST_NUM2:    if (mul_done) state_d = ST_SLOPE;
      ST_SLOPE:   if (mul_done) state_d = ST_SQ;
      ST_SQ:      if (mul_done) state_d = ST_YMUL;
      ST_YMUL:    if (mul_done) state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (op_q == OP_ADD) state_d = ST_DONE;
        else if (!in_add_q && k_q[0]) state_d = ST_PT;
        else state_d = ST_LOOP;
      end
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
    launch_d = (state_d != state_q) || relaunch;
  end

  // Unit control and operand selection.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = md_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_RED: begin
        div_n     = red_sel;
        div_start = launch_q;
      end
      ST_INV_DIV: begin
        div_n     = r0_q;
        div_d     = r1_q;
        div_start = launch_q;
      end
      ST_INV_MUL: begin
        mul_a     = qmod;
        mul_b     = i1_q;
        mul_start = launch_q;
      end
      ST_NUM1: begin
        mul_a     = vx_q;
        mul_b     = vx_q;
        mul_start = launch_q;
      end
      ST_NUM2: begin
        mul_a     = t1_q;
        mul_b     = c3;
        mul_start = launch_q;
      end
      ST_SLOPE: begin
        mul_a     = t1_q;
        mul_b     = w_q;
        mul_start = launch_q;
      end
      ST_SQ: begin
        mul_a     = s_q;
        mul_b     = s_q;
        mul_start = launch_q;
      end
      ST_YMUL: begin
        mul_a     = s_q;
        mul_b     = mod_sub(px, tx_q, md_q);
        mul_start = launch_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
      cfg_a_q  <= W'(2);
      cfg_m_q  <= W'(17);
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_CURVE_A) cfg_a_q <= cfg_wdata_i[W-1:0];
        if (cfg_addr_i == CFG_MODULUS) cfg_m_q <= cfg_wdata_i[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        ax_q  <= point_a_x_i[W-1:0];
        ay_q  <= point_a_y_i[W-1:0];
        bx_q  <= point_b_x_i[W-1:0];
        by_q  <= point_b_y_i[W-1:0];
        k_q   <= scalar_i[S-1:0];
        op_q  <= operation_i;
        md_q  <= (cfg_m_q < W'(3)) ? W'(3) : cfg_m_q;
        red_q <= 3'd0;
      end
      ST_RED: begin
        if (div_done) begin
          unique case (red_q)
            3'd0:    ux_q <= div_r;
            3'd1:    uy_q <= div_r;
            3'd2:    vx_q <= div_r;
            3'd3:    vy_q <= div_r;
            default: ar_q <= div_r;
          endcase
          red_q <= red_q + 3'd1;
        end
      end
      ST_SETUP: begin
        in_add_q <= 1'b1;
        dbl_q    <= 1'b0;
        if (op_q == OP_SCALE) begin
          vx_q <= ux_q;
          vy_q <= uy_q;
          k_q  <= k_q >> 1;
          if (!k_q[0]) begin
            ux_q <= '0;
            uy_q <= '0;
          end
        end
      end
      ST_LOOP: begin
        in_add_q <= 1'b0;
        dbl_q    <= 1'b1;
      end
      ST_PT: begin
        priority if (!dbl_q && u_zero) begin
          tx_q <= vx_q;
          ty_q <= vy_q;
        end else if (!dbl_q && v_zero) begin
          tx_q <= ux_q;
          ty_q <= uy_q;
        end else begin
          tx_q <= '0;
          ty_q <= '0;
          if (!dbl_q && ux_q == vx_q && uy_q == vy_q && uy_q != negvy) begin
            dbl_q <= 1'b1;
          end
        end
      end
      ST_DEN: begin
        r0_q <= md_q;
        r1_q <= den;
        i0_q <= '0;
        i1_q <= W'(1);
      end
      ST_INV_CHK: begin
        if (r1_q == '0) begin
          w_q  <= (r0_q == W'(1)) ? i0_q : '0;
          t1_q <= mod_sub(uy_q, vy_q, md_q);
        end
      end
      ST_INV_MUL: begin
        if (mul_done) begin
          r0_q <= r1_q;
          r1_q <= div_r;
          i0_q <= i1_q;
          i1_q <= mod_sub(i0_q, mul_p, md_q);
        end
      end
      ST_NUM1:  if (mul_done) t1_q <= mul_p;
      ST_NUM2:  if (mul_done) t1_q <= mod_add(mul_p, ar_q, md_q);
      ST_SLOPE: if (mul_done) s_q <= mul_p;
      ST_SQ: begin
        if (mul_done) tx_q <= mod_sub(mod_sub(mul_p, px, md_q), vx_q, md_q);
      end
      ST_YMUL:  if (mul_done) ty_q <= mod_sub(mul_p, py, md_q);
      ST_COMMIT: begin
        if (in_add_q) begin
          ux_q <= tx_q;
          uy_q <= ty_q;
        end else begin
          vx_q <= tx_q;
          vy_q <= ty_q;
        end
        if (op_q == OP_SCALE) begin
          if (!in_add_q && k_q[0]) begin
            in_add_q <= 1'b1;
            dbl_q    <= 1'b0;
          end else begin
            k_q <= k_q >> 1;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign busy                 = (state_q != ST_IDLE);
  assign done_o               = (state_q == ST_DONE);
  assign result_x_o           = 64'(ux_q);
  assign result_y_o           = 64'(uy_q);
  assign result_at_infinity_o = u_zero;

endmodule
`default_nettype wire

// ===== src/ecsm_checker.sv =====
// Port-level checker of the point arithmetic core and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module ecsm_checker import ecsm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [63:0] result_x_o,
  input wire logic [63:0] result_y_o,
  input wire logic        result_at_infinity_o
);

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item accepted but core not busy");

  a_done_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o)) else $error("core still busy after result");

  a_inf_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_at_infinity_o == (result_x_o == 64'd0 && result_y_o == 64'd0)))
    else $error("identity flag disagrees with coordinates");

endmodule

bind ec_affine_scalar_multiplier_core ecsm_checker u_ecsm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start                (start),
  .busy                 (busy),
  .done_o               (done_o),
  .result_x_o           (result_x_o),
  .result_y_o           (result_y_o),
  .result_at_infinity_o (result_at_infinity_o)
);
`default_nettype wire

// ===== tb/sv/ec_point_checker.sv =====
// Checker that predicts and compares every result item of the elliptic-curve core.
`timescale 1ns / 1ps
module ec_point_checker import ecsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        operation_i,
  input  wire logic [63:0] point_a_x_i,
  input  wire logic [63:0] point_a_y_i,
  input  wire logic [63:0] point_b_x_i,
  input  wire logic [63:0] point_b_y_i,
  input  wire logic [63:0] scalar_i,
  input  wire logic        done_i,
  input  wire logic [63:0] result_x_i,
  input  wire logic [63:0] result_y_i,
  input  wire logic        result_at_infinity_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
  } point_t;

  logic [63:0] coef_a;
  logic [63:0] prime_p;
  point_t      expected_points_q[$];

  function automatic logic [63:0] fadd(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic logic [63:0] fsub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p % {64'd0, m};
    return p[63:0];
  endfunction

  function automatic logic [63:0] finv(logic [63:0] v, logic [63:0] m);
    logic [63:0] r0, r1, t0, t1, q, nr, nt;
    r0 = m;
    r1 = v;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      nt = fsub(t0, fmul(q % m, t1, m), m);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    return (r0 == 1) ? t0 : 64'd0;
  endfunction

  function automatic point_t pdouble(point_t p, logic [63:0] m);
    point_t r;
    logic [63:0] den, num, s;
    r = '0;
    if (p.y == 0) return r;
    den = finv(fadd(p.y, p.y, m), m);
    num = fadd(fmul(fmul(p.x, p.x, m), 3 % m, m), coef_a % m, m);
    s = fmul(num, den, m);
    r.x = fsub(fsub(fmul(s, s, m), p.x, m), p.x, m);
    r.y = fsub(fmul(s, fsub(p.x, r.x, m), m), p.y, m);
    return r;
  endfunction

  function automatic point_t padd(point_t p, point_t q, logic [63:0] m);
    point_t r;
    logic [63:0] neg_y, s;
    r = '0;
    if (p == '0) return q;
    if (q == '0) return p;
    neg_y = (q.y != 0) ? m - q.y : 64'd0;
    if (p.x == q.x && p.y == neg_y) return r;
    if (p.x == q.x && p.y == q.y) return pdouble(p, m);
    s = fmul(fsub(p.y, q.y, m), finv(fsub(p.x, q.x, m), m), m);
    r.x = fsub(fsub(fmul(s, s, m), p.x, m), q.x, m);
    r.y = fsub(fmul(s, fsub(p.x, r.x, m), m), p.y, m);
    return r;
  endfunction

  function automatic point_t pscale(point_t p, logic [63:0] k, logic [63:0] m);
    point_t r, d;
    r = '0;
    d = p;
    if (k[0]) r = p;
    for (int i = 1; i < 64; i++) begin
      if ((k >> i) == 0) break;
      d = pdouble(d, m);
      if (k[i]) r = padd(r, d, m);
    end
    return r;
  endfunction

  function automatic point_t predict_point(logic op, logic [63:0] ax, logic [63:0] ay,
                                           logic [63:0] bx, logic [63:0] by, logic [63:0] k);
    logic [63:0] m;
    point_t a, b;
    m = (prime_p < 3) ? 64'd3 : prime_p;
    a.x = ax % m;
    a.y = ay % m;
    b.x = bx % m;
    b.y = by % m;
    return (op == OP_SCALE) ? pscale(a, k, m) : padd(a, b, m);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      coef_a <= 64'd2;
      prime_p <= 64'd17;
      fail_count_o <= 0;
      pending_o <= 0;
      expected_points_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_CURVE_A) coef_a <= cfg_wdata_i;
        else prime_p <= cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        expected_points_q.push_back(predict_point(operation_i, point_a_x_i, point_a_y_i,
                                                  point_b_x_i, point_b_y_i, scalar_i));
      end
      if (done_i) begin
        if (expected_points_q.size() == 0) begin
          $display("%0t: result item with none expected: x=%h y=%h inf=%b", $time,
                   result_x_i, result_y_i, result_at_infinity_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_points_q.pop_front();
          if (result_x_i !== e.x || result_y_i !== e.y ||
              result_at_infinity_i !== (e == '0)) begin
            $display("%0t: expected x=%h y=%h inf=%b, actual x=%h y=%h inf=%b", $time,
                     e.x, e.y, e == '0, result_x_i, result_y_i, result_at_infinity_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_points_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_ec_affine_scalar_multiplier_core.sv =====
// Testbench top that drives stimulus into the elliptic-curve core and reports the verdict.
`timescale 1ns / 1ps
module tb_ec_affine_scalar_multiplier_core;
  import ecsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        operation_i = 1'b0;
  logic [63:0] point_a_x_i = '0;
  logic [63:0] point_a_y_i = '0;
  logic [63:0] point_b_x_i = '0;
  logic [63:0] point_b_y_i = '0;
  logic [63:0] scalar_i = '0;
  logic        done_o;
  logic [63:0] result_x_o;
  logic [63:0] result_y_o;
  logic        result_at_infinity_o;
  int          fail_count;
  int          pending;
  int          idle_pct;
  int          stall_cycles;
  logic [63:0] field_p;

  ec_affine_scalar_multiplier_core dut (.*);

  ec_point_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .start_i(start), .busy_i(busy), .operation_i,
    .point_a_x_i, .point_a_y_i, .point_b_x_i, .point_b_y_i, .scalar_i,
    .done_i(done_o), .result_x_i(result_x_o), .result_y_i(result_y_o),
    .result_at_infinity_i(result_at_infinity_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(logic op, logic [63:0] ax, logic [63:0] ay, logic [63:0] bx,
                           logic [63:0] by, logic [63:0] k);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    point_a_x_i <= ax;
    point_a_y_i <= ay;
    point_b_x_i <= bx;
    point_b_y_i <= by;
    scalar_i <= k;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item(bit slow_field);
    logic [63:0] m, ax, ay, bx, by, k;
    m = (field_p < 3) ? 64'd3 : field_p;
    ax = rand64() % m;
    ay = ($urandom_range(7) == 0) ? 64'd0 : rand64() % m;
    bx = rand64() % m;
    by = rand64() % m;
    k = slow_field ? 64'($urandom_range(7)) :
        ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(255));
    case ($urandom_range(9))
      0: send_item($urandom_range(1) ? OP_SCALE : OP_ADD, rand64(), rand64(), rand64(),
                   rand64(), slow_field ? k : rand64());
      1: send_item(OP_ADD, ax, ay, ax, ay, rand64());
      2: send_item(OP_ADD, ax, ay, ax, (ay == 0) ? 64'd0 : m - ay, rand64());
      3: send_item(OP_ADD, $urandom_range(1) ? ax : 64'd0, 64'd0, bx, by, k);
      4: send_item(OP_ADD, ax, ay, ax, by, k);
      5: send_item(OP_ADD, ax, ay, bx, by, k);
      default: send_item(OP_SCALE, ax, ay, rand64(), rand64(), k);
    endcase
  endtask

  initial begin
    logic [63:0] phase_a[7];
    logic [63:0] phase_p[7];
    logic [63:0] ones;
    ones = '1;
    phase_a = '{64'd0, ones, 64'd5, 64'd3, 64'd7, 64'd1, 64'd2};
    phase_p = '{64'd97, 64'd0, 64'hFFFF_FFFF_FFFF_FFC5, 64'd91, 64'd2,
                64'd4294967291, 64'd17};
    field_p = 64'd17;
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_ADD, 0, 0, 0, 0, 0);
    send_item(OP_ADD, 5, 1, 0, 0, ones);
    send_item(OP_ADD, 0, 0, 6, 3, 0);
    send_item(OP_ADD, 5, 1, 5, 16, 0);
    send_item(OP_ADD, 5, 1, 5, 1, 0);
    send_item(OP_ADD, 3, 0, 3, 0, 0);
    send_item(OP_ADD, 5, 1, 6, 3, 0);
    send_item(OP_ADD, 5, 1, 5, 7, 0);
    send_item(OP_ADD, ones, ones, ones, ones, ones);
    send_item(OP_ADD, 22, 18, 6, 20, 0);
    send_item(OP_SCALE, 5, 1, ones, ones, 0);
    send_item(OP_SCALE, 5, 1, 0, 0, 1);
    send_item(OP_SCALE, 5, 1, 0, 0, 2);
    send_item(OP_SCALE, 5, 1, 0, 0, 19);
    send_item(OP_SCALE, 5, 1, 0, 0, ones);
    send_item(OP_SCALE, 5, 1, 0, 0, 64'h8000_0000_0000_0000);
    send_item(OP_SCALE, 0, 0, 7, 7, 13);
    send_item(OP_SCALE, ones, ones, 0, 0, ones);
    send_item(OP_SCALE, 3, 0, 0, 0, 6);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_CURVE_A, phase_a[ph]);
      write_reg(CFG_MODULUS, phase_p[ph]);
      field_p = phase_p[ph];
      for (int n = 0; n < 12; n++) begin
        case ((n / 3) % 4)
          0: idle_pct = 0;
          1: idle_pct = 86;
          2: idle_pct = 0;
          default: idle_pct = 22;
        endcase
        random_item(field_p > 64'd1000);
        if (n == 5) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ecsm_pkg.sv
src/ecsm_mulmod.sv
src/ecsm_divu.sv
src/ec_affine_scalar_multiplier_core.sv
src/ecsm_checker.sv
tb/sv/ec_point_checker.sv
tb/sv/tb_ec_affine_scalar_multiplier_core.sv
